/* rtl/core/csvrp_pkg.sv */
// ----------------------------------------------------------------------------
// csvrp_pkg: shared types and codes of the CSV row parser
// Byte classes, the queued item format and the result codes.
// ----------------------------------------------------------------------------
package csvrp_pkg;

	localparam logic [7:0] BYTE_NEWLINE = 8'd10;
	localparam logic [7:0] BYTE_COMMA   = 8'h2C;
	localparam logic [7:0] BYTE_QUOTE   = 8'h22;

	typedef enum logic [1:0] {
		CLS_OTHER   = 2'd0,
		CLS_NEWLINE = 2'd1,
		CLS_COMMA   = 2'd2,
		CLS_QUOTE   = 2'd3
	} byte_cls_t;

	typedef struct packed {
		logic      eos;
		byte_cls_t cls;
		logic [7:0] data;
	} item_t;

	localparam logic [1:0] KIND_CHAR       = 2'd0;
	localparam logic [1:0] KIND_FIELD_END  = 2'd1;
	localparam logic [1:0] KIND_ROW_END    = 2'd2;
	localparam logic [1:0] KIND_STREAM_END = 2'd3;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_EMPTY    = 3'd1;
	localparam logic [2:0] ERR_QUOTE    = 3'd2;
	localparam logic [2:0] ERR_MISMATCH = 3'd3;
	localparam logic [2:0] ERR_TOO_MANY = 3'd4;

	localparam int QUEUE_DEPTH = 2;

endpackage

/* rtl/core/csvrp_front.sv */
// ----------------------------------------------------------------------------
// csvrp_front: input stage of the CSV row parser
// Accepts input transactions, classifies each byte and hands it to the queue.
// ----------------------------------------------------------------------------
module csvrp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              opcode,
	input  logic [7:0]        data_byte,
	output logic              push,
	output csvrp_pkg::item_t  push_item,
	input  logic              push_ready
);
	import csvrp_pkg::*;

	logic      valid_s1;
	item_t     item_s1;
	byte_cls_t cls;

	always_comb begin
		case (data_byte)
			BYTE_NEWLINE: cls = CLS_NEWLINE;
			BYTE_COMMA:   cls = CLS_COMMA;
			BYTE_QUOTE:   cls = CLS_QUOTE;
			default:      cls = CLS_OTHER;
		endcase
	end

	assign in_ready  = !valid_s1 || push_ready;
	assign push      = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.eos  <= opcode;
			item_s1.cls  <= cls;
			item_s1.data <= data_byte;
		end
	end

endmodule

/* rtl/core/csvrp_queue.sv */
// ----------------------------------------------------------------------------
// csvrp_queue: short queue between the front and back of the parser
// A small first-in first-out buffer of classified items.
// ----------------------------------------------------------------------------
module csvrp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csvrp_pkg::item_t  push_item,
	output logic              push_ready,
	output logic              pop_valid,
	output csvrp_pkg::item_t  pop_item,
	input  logic              pop
);
	import csvrp_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	item_t             entry_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CNTW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNTW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/core/csvrp_back.sv */
// ----------------------------------------------------------------------------
// csvrp_back: parsing engine of the CSV row parser
// Tracks quote state, field and header counts, and registers each result.
// ----------------------------------------------------------------------------
module csvrp_back #(
	parameter int MAX_COLUMNS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	input  csvrp_pkg::item_t  pop_item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [7:0]        char_out,
	output logic [7:0]        col_index,
	output logic              header_row,
	output logic [2:0]        error_code
);
	import csvrp_pkg::*;

	localparam int CNB = $clog2(MAX_COLUMNS + 1);
	localparam int CW  = (CNB > 8) ? CNB : 8;
	localparam logic [CW:0] MAX_COLS = (CW + 1)'(MAX_COLUMNS);

	localparam logic [1:0] Q_UNQUOTED = 2'd0;
	localparam logic [1:0] Q_QUOTED   = 2'd1;
	localparam logic [1:0] Q_PENDING  = 2'd2;

	logic [1:0]    quote_mode_q;
	logic          header_seen_q;
	logic [CW-1:0] header_count_q;
	logic [CW-1:0] field_counter_q;
	logic          line_open_q;
	logic          failed_q;

	logic [1:0]    quote_mode_d;
	logic          header_seen_d;
	logic [CW-1:0] header_count_d;
	logic [CW-1:0] field_counter_d;
	logic          line_open_d;
	logic          clear;

	logic          emit;
	logic [1:0]    kind_d;
	logic [7:0]    char_d;
	logic [7:0]    col_d;
	logic          hdr_d;
	logic [2:0]    err_d;
	logic [2:0]    line_err;
	logic [CW:0]   fc_inc;
	logic          unq_path;
	logic          take;

	assign take = pop_valid && (!out_valid || out_ready);
	assign pop  = take;

	assign fc_inc = {1'b0, field_counter_q} + 1'b1;

	always_comb begin
		if (quote_mode_q == Q_QUOTED) begin
			line_err = ERR_QUOTE;
		end else if (header_seen_q && (fc_inc != {1'b0, header_count_q})) begin
			line_err = ERR_MISMATCH;
		end else begin
			line_err = ERR_NONE;
		end
	end

	always_comb begin
		quote_mode_d    = quote_mode_q;
		header_seen_d   = header_seen_q;
		header_count_d  = header_count_q;
		field_counter_d = field_counter_q;
		line_open_d     = line_open_q;
		clear           = 1'b0;
		emit            = 1'b0;
		kind_d          = KIND_CHAR;
		char_d          = 8'd0;
		col_d           = field_counter_q[7:0];
		hdr_d           = !header_seen_q;
		err_d           = ERR_NONE;
		unq_path        = 1'b0;
		if (pop_item.eos) begin
			emit   = 1'b1;
			kind_d = KIND_STREAM_END;
			if (!line_open_q) begin
				col_d = 8'd0;
				if (!header_seen_q) begin
					err_d = ERR_EMPTY;
				end else begin
					hdr_d = 1'b0;
					clear = 1'b1;
				end
			end else begin
				err_d = line_err;
				clear = (line_err == ERR_NONE);
			end
		end else if (pop_item.cls == CLS_NEWLINE) begin
			emit   = 1'b1;
			kind_d = KIND_ROW_END;
			err_d  = line_err;
			if (line_err == ERR_NONE) begin
				if (!header_seen_q) begin
					header_seen_d  = 1'b1;
					header_count_d = fc_inc[CW-1:0];
				end
				field_counter_d = '0;
				line_open_d     = 1'b0;
				quote_mode_d    = Q_UNQUOTED;
			end
		end else begin
			line_open_d = 1'b1;
			case (quote_mode_q)
				Q_QUOTED: begin
					if (pop_item.cls == CLS_QUOTE) begin
						quote_mode_d = Q_PENDING;
					end else begin
						emit   = 1'b1;
						char_d = pop_item.data;
					end
				end
				Q_PENDING: begin
					if (pop_item.cls == CLS_QUOTE) begin
						quote_mode_d = Q_QUOTED;
						emit         = 1'b1;
						char_d       = pop_item.data;
					end else begin
						quote_mode_d = Q_UNQUOTED;
						unq_path     = 1'b1;
					end
				end
				default: begin
					unq_path = 1'b1;
				end
			endcase
			if (unq_path) begin
				case (pop_item.cls)
					CLS_COMMA: begin
						emit   = 1'b1;
						kind_d = KIND_FIELD_END;
						if (fc_inc >= MAX_COLS) begin
							err_d = ERR_TOO_MANY;
						end else begin
							field_counter_d = fc_inc[CW-1:0];
						end
					end
					CLS_QUOTE: begin
						quote_mode_d = Q_QUOTED;
					end
					default: begin
						emit   = 1'b1;
						char_d = pop_item.data;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_mode_q    <= Q_UNQUOTED;
			header_seen_q   <= 1'b0;
			header_count_q  <= '0;
			field_counter_q <= '0;
			line_open_q     <= 1'b0;
			failed_q        <= 1'b0;
			out_valid       <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (take && !failed_q) begin
				if (emit) begin
					out_valid <= 1'b1;
				end
				if (emit && (err_d != ERR_NONE)) begin
					failed_q <= 1'b1;
				end
				if (clear) begin
					quote_mode_q    <= Q_UNQUOTED;
					header_seen_q   <= 1'b0;
					header_count_q  <= '0;
					field_counter_q <= '0;
					line_open_q     <= 1'b0;
				end else begin
					quote_mode_q    <= quote_mode_d;
					header_seen_q   <= header_seen_d;
					header_count_q  <= header_count_d;
					field_counter_q <= field_counter_d;
					line_open_q     <= line_open_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !failed_q && emit) begin
			kind       <= kind_d;
			char_out   <= char_d;
			col_index  <= col_d;
			header_row <= hdr_d;
			error_code <= err_d;
		end
	end

endmodule

/* rtl/core/csv_row_parser.sv */
// ----------------------------------------------------------------------------
// csv_row_parser: streaming parser for comma separated text
// Splits a byte stream into field characters, field ends and row ends,
// checks every row against the header's column count.
// ----------------------------------------------------------------------------
// The parser takes one byte transaction per clock and gives at most one result
// transaction per byte. A result passes through registers in this order: the
// classifying input stage loads at the edge that accepts its byte, then the
// two-entry queue, then the parsing engine's output register. The sustained
// rate of one byte per clock is set by the parsing engine, which updates its
// quote and column state for each byte it takes; the input side stalls only
// when the queue fills behind a stalled output.
module csv_row_parser #(
	parameter int MAX_COLUMNS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       opcode,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] char_out,
	output logic [7:0] col_index,
	output logic       header_row,
	output logic [2:0] error_code
);
	import csvrp_pkg::*;

	logic  push;
	logic  push_ready;
	item_t push_item;
	logic  pop;
	logic  pop_valid;
	item_t pop_item;

	csvrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.data_byte  (data_byte),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	csvrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop)
	);

	csvrp_back #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.char_out   (char_out),
		.col_index  (col_index),
		.header_row (header_row),
		.error_code (error_code)
	);

endmodule

/* tb/tb_csv_row_parser.sv */
// ----------------------------------------------------------------------------
// tb_csv_row_parser: self-checking testbench for the CSV row parser
// Feeds byte transactions (data bytes and end-of-stream marks) into the
// parser and predicts every field character, field end, row end and stream
// end, with column index, header flag and error code. Directed files cover
// quoting corner cases; random well-formed files with random content follow,
// including one file of the widest allowed rows. One error case, picked at
// random, closes the run, since an error sticks until reset.
// ----------------------------------------------------------------------------
module tb_csv_row_parser;
	import csvrp_pkg::*;

	localparam int MAX_COLS = 256;
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_EOS = 1'b1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_STALL = 120;
	localparam int RANDOM_ITEMS = 1100;

	typedef enum logic [1:0] {
		QS_PLAIN,
		QS_QUOTED,
		QS_AFTER_QUOTE
	} quote_state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_out;
		logic [7:0] col_index;
		logic       header_row;
		logic [2:0] error_code;
	} parse_token_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic opcode = 1'b0;
	logic [7:0] data_byte = 8'd0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	logic [1:0] kind;
	logic [7:0] char_out;
	logic [7:0] col_index;
	logic header_row;
	logic [2:0] error_code;

	parse_token_t expected_tokens[$];
	quote_state_t quote_state = QS_PLAIN;
	logic header_done = 1'b0;
	int header_cols = 0;
	int field_idx = 0;
	logic line_started = 1'b0;
	logic parse_failed = 1'b0;

	int fail_count = 0;
	int results_checked = 0;
	int items_sent = 0;
	int files_sent = 0;
	int cycle_count = 0;
	logic [2:0] error_case = ERR_NONE;
	bit no_idle = 1'b0;
	int stall_requests = 0;
	int stall_seen = 0;
	int stall_left = 0;

	csv_row_parser #(
		.MAX_COLUMNS(MAX_COLS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.char_out(char_out),
		.col_index(col_index),
		.header_row(header_row),
		.error_code(error_code)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_requests != stall_seen) begin
			stall_seen = stall_requests;
			stall_left = LONG_STALL;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= no_idle || ($urandom_range(99) >= 7);
	end

	function automatic void clear_parse_state();
		quote_state = QS_PLAIN;
		header_done = 1'b0;
		header_cols = 0;
		field_idx = 0;
		line_started = 1'b0;
		parse_failed = 1'b0;
	endfunction

	function automatic void add_token(input logic [1:0] k, input logic [7:0] ch, input int col,
			input logic hdr, input logic [2:0] err);
		parse_token_t t;
		t.kind = k;
		t.char_out = ch;
		t.col_index = col[7:0];
		t.header_row = hdr;
		t.error_code = err;
		expected_tokens = {expected_tokens, t};
		if (err != ERR_NONE) begin
			parse_failed = 1'b1;
		end
	endfunction

	function automatic logic [2:0] line_end_status();
		if (quote_state == QS_QUOTED) begin
			return ERR_QUOTE;
		end
		if (header_done && field_idx + 1 != header_cols) begin
			return ERR_MISMATCH;
		end
		return ERR_NONE;
	endfunction

	function automatic void parse_step(input logic op, input logic [7:0] b);
		logic hdr;
		logic [2:0] err;
		hdr = !header_done;
		if (parse_failed) begin
			return;
		end
		if (op == OP_EOS) begin
			if (!line_started) begin
				if (!header_done) begin
					add_token(KIND_STREAM_END, 8'd0, 0, 1'b1, ERR_EMPTY);
				end else begin
					add_token(KIND_STREAM_END, 8'd0, 0, 1'b0, ERR_NONE);
					clear_parse_state();
				end
				return;
			end
			err = line_end_status();
			add_token(KIND_STREAM_END, 8'd0, field_idx, hdr, err);
			if (err == ERR_NONE) begin
				clear_parse_state();
			end
			return;
		end
		if (b == BYTE_NEWLINE) begin
			err = line_end_status();
			add_token(KIND_ROW_END, 8'd0, field_idx, hdr, err);
			if (err == ERR_NONE) begin
				if (!header_done) begin
					header_done = 1'b1;
					header_cols = field_idx + 1;
				end
				field_idx = 0;
				line_started = 1'b0;
				quote_state = QS_PLAIN;
			end
			return;
		end
		line_started = 1'b1;
		if (quote_state == QS_QUOTED) begin
			if (b == BYTE_QUOTE) begin
				quote_state = QS_AFTER_QUOTE;
			end else begin
				add_token(KIND_CHAR, b, field_idx, hdr, ERR_NONE);
			end
			return;
		end
		if (quote_state == QS_AFTER_QUOTE) begin
			if (b == BYTE_QUOTE) begin
				quote_state = QS_QUOTED;
				add_token(KIND_CHAR, b, field_idx, hdr, ERR_NONE);
				return;
			end
			quote_state = QS_PLAIN;
		end
		if (b == BYTE_COMMA) begin
			if (field_idx + 1 >= MAX_COLS) begin
				add_token(KIND_FIELD_END, 8'd0, field_idx, hdr, ERR_TOO_MANY);
			end else begin
				add_token(KIND_FIELD_END, 8'd0, field_idx, hdr, ERR_NONE);
				field_idx++;
			end
		end else if (b == BYTE_QUOTE) begin
			quote_state = QS_QUOTED;
		end else begin
			add_token(KIND_CHAR, b, field_idx, hdr, ERR_NONE);
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		parse_token_t want;
		if (out_valid === 1'b1 && out_ready) begin
			if (expected_tokens.size() == 0) begin
				$error("result transaction with nothing expected: kind %0d", kind);
				fail_count++;
			end else begin
				want = expected_tokens.pop_front();
				check_field("kind", 8'(want.kind), 8'(kind));
				check_field("char_out", want.char_out, char_out);
				check_field("col_index", want.col_index, col_index);
				check_field("header_row", 8'(want.header_row), 8'(header_row));
				check_field("error_code", 8'(want.error_code), 8'(error_code));
				results_checked++;
			end
		end
	end

	// Valid is left high after acceptance; the next call either changes the
	// payload or lowers valid for a gap, so each step gets one assignment.
	task automatic send_item(input logic op, input logic [7:0] b);
		if (!no_idle) begin
			while ($urandom_range(99) < 7) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		opcode <= op;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		parse_step(op, b);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(OP_DATA, b);
	endtask

	task automatic send_eos();
		send_item(OP_EOS, 8'($urandom_range(255)));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == BYTE_NEWLINE || b == BYTE_COMMA || b == BYTE_QUOTE);
		return b;
	endfunction

	task automatic send_quoted_byte();
		logic [7:0] b;
		if ($urandom_range(5) == 0) begin
			b = BYTE_COMMA;
		end else begin
			b = 8'($urandom_range(255));
			while (b == BYTE_NEWLINE) begin
				b = 8'($urandom_range(255));
			end
		end
		send_byte(b);
		if (b == BYTE_QUOTE) begin
			send_byte(BYTE_QUOTE);
		end
	endtask

	task automatic send_random_field();
		int segs;
		int len;
		segs = $urandom_range(0, 3);
		for (int s = 0; s < segs; s++) begin
			len = $urandom_range(0, 4);
			if ($urandom_range(2) == 0) begin
				send_byte(BYTE_QUOTE);
				for (int i = 0; i < len; i++) begin
					send_quoted_byte();
				end
				send_byte(BYTE_QUOTE);
			end else begin
				for (int i = 0; i < len; i++) begin
					send_byte(plain_byte());
				end
			end
		end
	endtask

	// A row that sent no byte always gets its newline, so that a lone empty
	// header line cannot turn the file into an empty table.
	task automatic send_random_file(input int ncols, input int nrows);
		int row_start;
		for (int r = 0; r <= nrows; r++) begin
			row_start = items_sent;
			for (int c = 0; c < ncols; c++) begin
				if (c != 0) begin
					send_byte(BYTE_COMMA);
				end
				if (ncols < 16 || $urandom_range(15) == 0) begin
					send_random_field();
				end
			end
			if (r < nrows || items_sent == row_start || $urandom_range(1) == 0) begin
				send_byte(BYTE_NEWLINE);
			end
		end
		send_eos();
		files_sent++;
	endtask

	task automatic test_directed_quoting();
		send_text("a,\"x\"\"y\"\n");
		send_byte(8'hFF);
		send_text(",\"q\"");
		send_item(OP_EOS, 8'hFF);
		send_byte(8'h00);
		send_text("\"z\"\n\n");
		send_item(OP_EOS, 8'hA5);
		files_sent += 2;
	endtask

	// Broken files are kept out of this part: any error would silence the
	// parser for the rest of the run.
	task automatic test_random_files();
		int base_items;
		int round;
		bit stall_done;
		base_items = items_sent;
		round = 0;
		stall_done = 1'b0;
		while (items_sent - base_items < RANDOM_ITEMS) begin
			no_idle = (items_sent - base_items >= 250) && (items_sent - base_items < 650);
			if (!stall_done && items_sent - base_items >= 300) begin
				stall_requests++;
				stall_done = 1'b1;
			end
			if (round == 3) begin
				send_random_file(MAX_COLS, 1);
			end else begin
				send_random_file($urandom_range(1, 6), $urandom_range(0, 4));
			end
			round++;
		end
		no_idle = 1'b0;
	endtask

	task automatic test_sticky_error();
		error_case = 3'($urandom_range(ERR_EMPTY, ERR_TOO_MANY));
		case (error_case)
			ERR_EMPTY: begin
				send_eos();
			end
			ERR_QUOTE: begin
				send_text("h1,h2\nv,\"open");
				if ($urandom_range(1) == 0) begin
					send_byte(BYTE_NEWLINE);
				end else begin
					send_eos();
				end
			end
			ERR_MISMATCH: begin
				send_text("h1,h2\n");
				if ($urandom_range(1) == 0) begin
					send_text("only\n");
				end else begin
					send_text("a,b,c");
					send_eos();
				end
			end
			default: begin
				for (int i = 0; i < MAX_COLS; i++) begin
					send_byte(BYTE_COMMA);
				end
			end
		endcase
		for (int i = 0; i < 20; i++) begin
			send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
		end
	endtask

	task automatic finish_run();
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d files in %0d input transactions, %0d results checked.",
			files_sent, items_sent, results_checked);
		$display("The run closed on error code %0d, which then held for all later input.",
			error_case);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_quoting();
		test_random_files();
		test_sticky_error();
		finish_run();
	end

endmodule
